[rtl/table_linear_interpolator_core_macros.svh]
// ----------------------------------------------------------------------------
// Table linear interpolator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH

// same-cycle implication
`define TLI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tli_pkg.sv]
// ----------------------------------------------------------------------------
// Table linear interpolator package
// Widths, types, codes and sequencer states shared by the interpolator RTL.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int VW          = 32;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int PROD_W      = 2 * VW + 1;
    localparam int REM_W       = VW + 2;
    localparam int QUOT_W      = VW + 2;
    localparam int ADD_W       = VW + 3;
    localparam int CNT_W       = $clog2(PROD_W);

    typedef logic signed [VW-1:0]   value_t;
    typedef logic signed [VW:0]     xval_t;
    typedef logic signed [VW+1:0]   wide_t;
    typedef logic signed [VW+2:0]   sum_t;
    typedef logic [VW-1:0]          ymag_t;
    typedef logic [VW:0]            mag_t;
    typedef logic [PROD_W-1:0]      prod_t;
    typedef logic [REM_W-1:0]       rem_t;
    typedef logic [QUOT_W-1:0]      quot_t;
    typedef logic [ADD_W-1:0]       add_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [TBL_AW-1:0]      addr_t;
    typedef logic [7:0]             seg_t;
    typedef logic [8:0]             pts_t;
    typedef logic [1:0]             cfg_idx_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam cfg_idx_t CFG_EXTRAP = 2'd0;
    localparam cfg_idx_t CFG_POINTS = 2'd1;
    localparam cfg_idx_t CFG_OFFSET = 2'd2;

    localparam pts_t   PT_MIN   = 9'd2;
    localparam pts_t   PT_LIMIT = pts_t'((TABLE_DEPTH < 256) ? TABLE_DEPTH : 256);
    localparam value_t VMAX     = {1'b0, {(VW-1){1'b1}}};
    localparam value_t VMIN     = {1'b1, {(VW-1){1'b0}}};
    localparam quot_t  QUOT_CAP = quot_t'(1) << (VW + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_LAST,
        ST_SEARCH,
        ST_FETCH_L,
        ST_FETCH_R,
        ST_PREP,
        ST_DIFF,
        ST_LAUNCH,
        ST_WAIT,
        ST_SUM
    } state_t;

    typedef enum logic [1:0] {
        AR_IDLE,
        AR_MUL,
        AR_DIV,
        AR_CLAMP
    } arith_phase_t;

    typedef struct packed {
        logic  go;
        ymag_t mcand;
        mag_t  mplier;
        mag_t  divisor;
    } arith_req_t;

    typedef struct packed {
        logic  done;
        quot_t quot;
    } arith_rsp_t;

endpackage

[rtl/tli_table.sv]
// ----------------------------------------------------------------------------
// Breakpoint table
// x and y breakpoint memories, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tli_table
(
    input  logic            clk,
    input  logic            wr_en,
    input  tli_pkg::addr_t  wr_addr,
    input  tli_pkg::value_t wr_x,
    input  tli_pkg::value_t wr_y,
    input  tli_pkg::addr_t  rd_addr,
    output tli_pkg::value_t rd_x,
    output tli_pkg::value_t rd_y
);

    tli_pkg::value_t x_mem [tli_pkg::TABLE_DEPTH];
    tli_pkg::value_t y_mem [tli_pkg::TABLE_DEPTH];
    tli_pkg::value_t rd_x_reg;
    tli_pkg::value_t rd_y_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    assign rd_x = rd_x_reg;
    assign rd_y = rd_y_reg;

endmodule

[rtl/tli_arith.sv]
// ----------------------------------------------------------------------------
// Shared multiply-divide unit
// One adder runs a shift-add multiply, then a restoring divide of the
// product, then clamps the quotient to the saturation cap.
// ----------------------------------------------------------------------------
module tli_arith
(
    input  logic                clk,
    input  logic                rst_n,
    input  tli_pkg::arith_req_t req,
    output tli_pkg::arith_rsp_t rsp
);

    tli_pkg::arith_phase_t phase_reg;
    tli_pkg::arith_phase_t phase_next;
    tli_pkg::cnt_t         cnt_reg;
    tli_pkg::cnt_t         cnt_next;
    logic                  done_reg;
    logic                  done_next;
    tli_pkg::rem_t         acc_reg;
    tli_pkg::rem_t         acc_next;
    tli_pkg::prod_t        lo_reg;
    tli_pkg::prod_t        lo_next;
    tli_pkg::ymag_t        mcand_reg;
    tli_pkg::ymag_t        mcand_next;
    tli_pkg::mag_t         divisor_reg;
    tli_pkg::mag_t         divisor_next;
    tli_pkg::quot_t        quot_reg;
    tli_pkg::quot_t        quot_next;

    tli_pkg::add_t         add_a;
    tli_pkg::add_t         add_b;
    logic                  add_cin;
    tli_pkg::add_t         add_sum;
    tli_pkg::rem_t         div_r;
    logic                  div_bit;
    tli_pkg::rem_t         div_acc;
    tli_pkg::rem_t         mul_acc;
    tli_pkg::mag_t         mul_lo;
    logic                  quot_over;

    assign div_r = {acc_reg[tli_pkg::VW:0], lo_reg[tli_pkg::PROD_W-1]};

    always_comb
    begin
        if (phase_reg == tli_pkg::AR_DIV)
        begin
            add_a   = tli_pkg::add_t'(div_r);
            add_b   = ~tli_pkg::add_t'(divisor_reg);
            add_cin = 1'b1;
        end
        else
        begin
            add_a   = tli_pkg::add_t'(acc_reg[tli_pkg::VW:0]);
            add_b   = lo_reg[0] ? tli_pkg::add_t'(mcand_reg) : '0;
            add_cin = 1'b0;
        end
    end

    assign add_sum   = add_a + add_b + tli_pkg::add_t'(add_cin);
    assign mul_acc   = tli_pkg::rem_t'(add_sum[tli_pkg::VW:1]);
    assign mul_lo    = {add_sum[0], lo_reg[tli_pkg::VW:1]};
    assign div_bit   = ~add_sum[tli_pkg::ADD_W-1];
    assign div_acc   = div_bit ? add_sum[tli_pkg::REM_W-1:0] : div_r;
    assign quot_over = (lo_reg[tli_pkg::PROD_W-1:tli_pkg::QUOT_W] != '0)
                    || (lo_reg[tli_pkg::QUOT_W-1:0] > tli_pkg::QUOT_CAP);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            tli_pkg::AR_IDLE:
            begin
                if (req.go)
                begin
                    phase_next = tli_pkg::AR_MUL;
                end
            end
            tli_pkg::AR_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    phase_next = tli_pkg::AR_DIV;
                end
            end
            tli_pkg::AR_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    phase_next = tli_pkg::AR_CLAMP;
                end
            end
            tli_pkg::AR_CLAMP:
            begin
                phase_next = tli_pkg::AR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        lo_next      = lo_reg;
        mcand_next   = mcand_reg;
        divisor_next = divisor_reg;
        quot_next    = quot_reg;
        done_next    = 1'b0;
        unique case (phase_reg)
            tli_pkg::AR_IDLE:
            begin
                if (req.go)
                begin
                    mcand_next   = req.mcand;
                    divisor_next = req.divisor;
                    acc_next     = '0;
                    lo_next      = tli_pkg::prod_t'(req.mplier);
                    cnt_next     = tli_pkg::cnt_t'(tli_pkg::VW);
                end
            end
            tli_pkg::AR_MUL:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    acc_next = '0;
                    lo_next  = {mul_acc[tli_pkg::VW-1:0], mul_lo};
                    cnt_next = tli_pkg::cnt_t'(tli_pkg::PROD_W - 1);
                end
                else
                begin
                    acc_next = mul_acc;
                    lo_next  = {lo_reg[tli_pkg::PROD_W-1:tli_pkg::VW+1], mul_lo};
                end
            end
            tli_pkg::AR_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                acc_next = div_acc;
                lo_next  = {lo_reg[tli_pkg::PROD_W-2:0], div_bit};
            end
            tli_pkg::AR_CLAMP:
            begin
                quot_next = quot_over ? tli_pkg::QUOT_CAP : lo_reg[tli_pkg::QUOT_W-1:0];
                done_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tli_pkg::AR_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        lo_reg      <= lo_next;
        mcand_reg   <= mcand_next;
        divisor_reg <= divisor_next;
        quot_reg    <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

[rtl/table_linear_interpolator_core.sv]
// ----------------------------------------------------------------------------
// Table linear interpolator core
// Piecewise linear interpolation over a loaded breakpoint table, Q16.16.
// ----------------------------------------------------------------------------
// A load transaction writes one breakpoint and the block stays ready, so
// loads run back to back. A query transaction holds busy until its result is
// shown; a query that lands on the last segment skips the linear segment
// search, and a zero-width segment skips the arithmetic. The time is set by
// the one-entry-per-cycle search through the table read port and by the
// shared adder, which runs a 33-step multiply and a 65-step divide. Each
// result is shown for exactly one cycle with done high and cannot be stalled.
// Configuration writes are always ready; the point count is taken when a
// query is accepted, while the extrapolation and offset settings are read live.
`include "table_linear_interpolator_core_macros.svh"

module table_linear_interpolator_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [7:0]         entry_index,
    input  tli_pkg::value_t    load_x,
    input  tli_pkg::value_t    load_y,
    input  tli_pkg::value_t    query_x,
    output logic               done,
    output tli_pkg::value_t    interp_y,
    output logic [7:0]         segment_index,
    output logic               zero_width_fault,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  tli_pkg::cfg_idx_t  cfg_index,
    input  tli_pkg::pts_t      cfg_data
);

    tli_pkg::state_t     state_reg;
    tli_pkg::state_t     state_next;
    logic                extrap_reg;
    tli_pkg::pts_t       points_reg;
    logic                offset_reg;
    logic                done_reg;
    logic                done_next;

    tli_pkg::value_t     q_reg;
    tli_pkg::pts_t       n_reg;
    tli_pkg::xval_t      base_reg;
    tli_pkg::seg_t       seg_reg;
    tli_pkg::xval_t      xl_reg;
    tli_pkg::xval_t      xr_reg;
    tli_pkg::value_t     yl_reg;
    tli_pkg::value_t     yr_reg;
    tli_pkg::value_t     ylc_reg;
    tli_pkg::value_t     yrc_reg;
    tli_pkg::wide_t      w_reg;
    tli_pkg::wide_t      dx_reg;
    tli_pkg::xval_t      dy_reg;
    tli_pkg::mag_t       wmag_reg;
    tli_pkg::mag_t       dxmag_reg;
    logic                wzero_reg;
    logic                neg_reg;
    tli_pkg::value_t     interp_y_reg;
    tli_pkg::seg_t       seg_out_reg;
    logic                fault_reg;

    logic                accept;
    logic                load_ok;
    tli_pkg::pts_t       n_clamp;
    tli_pkg::pts_t       n_minus2;
    tli_pkg::pts_t       seg_p2;
    tli_pkg::addr_t      rd_addr;
    tli_pkg::value_t     rd_x;
    tli_pkg::value_t     rd_y;
    tli_pkg::xval_t      rd_xk;
    tli_pkg::xval_t      q_ext;
    logic                last_hit;
    logic                search_go;
    tli_pkg::value_t     ylc_c;
    tli_pkg::value_t     yrc_c;
    tli_pkg::wide_t      w_c;
    tli_pkg::wide_t      dx_c;
    tli_pkg::xval_t      dy_c;
    tli_pkg::ymag_t      dymag_c;
    logic                neg_c;
    tli_pkg::sum_t       sum_c;
    logic                sum_ovf;
    tli_pkg::value_t     sat_c;
    tli_pkg::arith_req_t arith_req;
    tli_pkg::arith_rsp_t arith_rsp;

    assign busy      = (state_reg != tli_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign load_ok   = (int'(entry_index) < tli_pkg::TABLE_DEPTH);
    assign cfg_ready = 1'b1;

    tli_table u_table
    (
        .clk     (clk),
        .wr_en   (accept && (opcode == tli_pkg::OP_LOAD) && load_ok),
        .wr_addr (tli_pkg::addr_t'(entry_index)),
        .wr_x    (load_x),
        .wr_y    (load_y),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    tli_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .rsp   (arith_rsp)
    );

    always_comb
    begin
        priority if (points_reg < tli_pkg::PT_MIN)
        begin
            n_clamp = tli_pkg::PT_MIN;
        end
        else if (points_reg > tli_pkg::PT_LIMIT)
        begin
            n_clamp = tli_pkg::PT_LIMIT;
        end
        else
        begin
            n_clamp = points_reg;
        end
    end

    assign n_minus2  = n_reg - 9'd2;
    assign seg_p2    = {1'b0, seg_reg} + 9'd2;
    assign rd_xk     = tli_pkg::xval_t'(rd_x) - base_reg;
    assign q_ext     = tli_pkg::xval_t'(q_reg);
    assign last_hit  = (q_ext >= rd_xk);
    assign search_go = (seg_p2 < n_reg) && (q_ext > rd_xk);

    always_comb
    begin
        ylc_c = yl_reg;
        yrc_c = yr_reg;
        if (!extrap_reg)
        begin
            if (q_ext < xl_reg)
            begin
                yrc_c = yl_reg;
            end
            if (q_ext > xr_reg)
            begin
                ylc_c = yrc_c;
            end
        end
    end

    assign w_c     = tli_pkg::wide_t'(xr_reg) - tli_pkg::wide_t'(xl_reg);
    assign dx_c    = tli_pkg::wide_t'(q_reg) - tli_pkg::wide_t'(xl_reg);
    assign dy_c    = tli_pkg::xval_t'(yrc_reg) - tli_pkg::xval_t'(ylc_reg);
    assign dymag_c = tli_pkg::ymag_t'(dy_reg[tli_pkg::VW] ? -dy_reg : dy_reg);
    assign neg_c   = (dy_reg[tli_pkg::VW] ^ dx_reg[tli_pkg::VW+1]) ^ w_reg[tli_pkg::VW+1];

    always_comb
    begin
        if (neg_reg)
        begin
            sum_c = tli_pkg::sum_t'(ylc_reg) - tli_pkg::sum_t'(arith_rsp.quot);
        end
        else
        begin
            sum_c = tli_pkg::sum_t'(ylc_reg) + tli_pkg::sum_t'(arith_rsp.quot);
        end
    end

    assign sum_ovf = (sum_c[tli_pkg::VW+2:tli_pkg::VW-1] != '0)
                  && (sum_c[tli_pkg::VW+2:tli_pkg::VW-1] != '1);
    assign sat_c   = !sum_ovf ? tli_pkg::value_t'(sum_c)
                   : (sum_c[tli_pkg::VW+2] ? tli_pkg::VMIN : tli_pkg::VMAX);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tli_pkg::ST_IDLE:
            begin
                if (accept && (opcode == tli_pkg::OP_QUERY))
                begin
                    state_next = tli_pkg::ST_BASE;
                end
            end
            tli_pkg::ST_BASE:
            begin
                state_next = tli_pkg::ST_LAST;
            end
            tli_pkg::ST_LAST:
            begin
                state_next = last_hit ? tli_pkg::ST_FETCH_L : tli_pkg::ST_SEARCH;
            end
            tli_pkg::ST_SEARCH:
            begin
                if (!search_go)
                begin
                    state_next = tli_pkg::ST_FETCH_L;
                end
            end
            tli_pkg::ST_FETCH_L:
            begin
                state_next = tli_pkg::ST_FETCH_R;
            end
            tli_pkg::ST_FETCH_R:
            begin
                state_next = tli_pkg::ST_PREP;
            end
            tli_pkg::ST_PREP:
            begin
                state_next = tli_pkg::ST_DIFF;
            end
            tli_pkg::ST_DIFF:
            begin
                state_next = tli_pkg::ST_LAUNCH;
            end
            tli_pkg::ST_LAUNCH:
            begin
                state_next = wzero_reg ? tli_pkg::ST_IDLE : tli_pkg::ST_WAIT;
            end
            tli_pkg::ST_WAIT:
            begin
                if (arith_rsp.done)
                begin
                    state_next = tli_pkg::ST_SUM;
                end
            end
            tli_pkg::ST_SUM:
            begin
                state_next = tli_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tli_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_addr           = '0;
        done_next         = 1'b0;
        arith_req.go      = 1'b0;
        arith_req.mcand   = dymag_c;
        arith_req.mplier  = dxmag_reg;
        arith_req.divisor = wmag_reg;
        unique case (state_reg)
            tli_pkg::ST_BASE:
            begin
                rd_addr = tli_pkg::addr_t'(n_minus2);
            end
            tli_pkg::ST_LAST:
            begin
                rd_addr = last_hit ? tli_pkg::addr_t'(n_minus2) : tli_pkg::addr_t'(1);
            end
            tli_pkg::ST_SEARCH:
            begin
                rd_addr = search_go ? tli_pkg::addr_t'(seg_p2) : tli_pkg::addr_t'(seg_reg);
            end
            tli_pkg::ST_FETCH_L:
            begin
                rd_addr = tli_pkg::addr_t'(seg_reg + 8'd1);
            end
            tli_pkg::ST_LAUNCH:
            begin
                arith_req.go = !wzero_reg;
                done_next    = wzero_reg;
            end
            tli_pkg::ST_SUM:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tli_pkg::ST_IDLE;
            done_reg   <= 1'b0;
            extrap_reg <= 1'b0;
            points_reg <= tli_pkg::PT_MIN;
            offset_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tli_pkg::CFG_EXTRAP: extrap_reg <= cfg_data[0];
                    tli_pkg::CFG_POINTS: points_reg <= cfg_data;
                    tli_pkg::CFG_OFFSET: offset_reg <= cfg_data[0];
                    default:             extrap_reg <= extrap_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tli_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    q_reg <= query_x;
                    n_reg <= n_clamp;
                end
            end
            tli_pkg::ST_BASE:
            begin
                base_reg <= offset_reg ? tli_pkg::xval_t'(rd_x) : '0;
            end
            tli_pkg::ST_LAST:
            begin
                seg_reg <= last_hit ? tli_pkg::seg_t'(n_minus2) : '0;
            end
            tli_pkg::ST_SEARCH:
            begin
                if (search_go)
                begin
                    seg_reg <= seg_reg + 8'd1;
                end
            end
            tli_pkg::ST_FETCH_L:
            begin
                xl_reg <= rd_xk;
                yl_reg <= rd_y;
            end
            tli_pkg::ST_FETCH_R:
            begin
                xr_reg <= rd_xk;
                yr_reg <= rd_y;
            end
            tli_pkg::ST_PREP:
            begin
                ylc_reg <= ylc_c;
                yrc_reg <= yrc_c;
                w_reg   <= w_c;
                dx_reg  <= dx_c;
            end
            tli_pkg::ST_DIFF:
            begin
                dy_reg    <= dy_c;
                wmag_reg  <= tli_pkg::mag_t'(w_reg[tli_pkg::VW+1] ? -w_reg : w_reg);
                dxmag_reg <= tli_pkg::mag_t'(dx_reg[tli_pkg::VW+1] ? -dx_reg : dx_reg);
                wzero_reg <= (w_reg == '0);
            end
            tli_pkg::ST_LAUNCH:
            begin
                neg_reg <= neg_c;
                if (wzero_reg)
                begin
                    interp_y_reg <= ylc_reg;
                    seg_out_reg  <= seg_reg;
                    fault_reg    <= 1'b1;
                end
            end
            tli_pkg::ST_WAIT:
            begin
                neg_reg <= neg_reg;
            end
            tli_pkg::ST_SUM:
            begin
                interp_y_reg <= sat_c;
                seg_out_reg  <= seg_reg;
                fault_reg    <= 1'b0;
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
    end

    assign done             = done_reg;
    assign interp_y         = interp_y_reg;
    assign segment_index    = seg_out_reg;
    assign zero_width_fault = fault_reg;

    `TLI_ASSERT_SAME(a_done_in_idle, done_reg, state_reg == tli_pkg::ST_IDLE, "result outside idle")
    `TLI_ASSERT_NEXT(a_query_starts, accept && (opcode == tli_pkg::OP_QUERY), state_reg == tli_pkg::ST_BASE, "query not started")
    `TLI_ASSERT_SAME(a_arith_in_wait, arith_rsp.done, state_reg == tli_pkg::ST_WAIT, "arith done outside wait")
    `TLI_ASSERT_SAME(a_search_bound, state_reg == tli_pkg::ST_SEARCH, seg_p2 <= n_reg, "search past last segment")

endmodule
